### sv/apcd_pkg.sv
package apcd_pkg;

    // Table size and register reset values
    localparam int unsigned TableEntriesDefault = 32;
    localparam logic [31:0] LeaseDefault        = 32'd86400;
    localparam logic [7:0]  FactorDefault       = 8'd5;

    // Change events reported per pairing at most
    localparam int unsigned MaxChangeEvents = 2;

    // Configuration register indexes
    typedef enum logic {
        REG_LEASE  = 1'b0,
        REG_FACTOR = 1'b1
    } reg_index_t;

    // Result kinds
    typedef enum logic [2:0] {
        EV_REFRESH     = 3'd0,
        EV_MAC_CHANGED = 3'd1,
        EV_IP_CHANGED  = 3'd2,
        EV_NEW         = 3'd3,
        EV_ADDED       = 3'd4,
        EV_PROTECTED   = 3'd5
    } event_kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROT,
        ST_WALK,
        ST_INSERT
    } state_t;

    // Table update selected per cycle
    typedef enum logic [1:0] {
        OP_NONE,
        OP_DELETE,
        OP_REFRESH,
        OP_INSERT
    } table_op_t;

    // One stored pairing
    typedef struct packed {
        logic [7:0]  iface;
        logic [47:0] hw;
        logic        v6;
        logic [63:0] ip_up;
        logic [63:0] ip_lo;
        logic [31:0] ts;
    } entry_t;

endpackage

### sv/address_pairing_change_detector.sv
// Channel | Direction | Signals                          | Transaction
// s_      | in        | tvalid tready tdata tuser        | one observed pairing
// m_      | out       | tvalid tready tdata tuser tlast  | one result (1 to 3 per pairing)
// cfg_    | in        | cfg_valid cfg_ready cfg_index    | one register write
//                       cfg_data
// Between one input transaction and the next, an item walks the live entries (count,
// at most TABLE_ENTRIES), comparing one table entry per cycle in a single shared match
// unit unless a full output register holds it; a refresh ends the walk, else it leaves
// the walk, inserts and returns to idle. A protected item goes via ST_PROT to idle.
// Results wait in one output register; a full one stalls the walk at the next result.
// Reset empties the table at once (fill count cleared) and restores register defaults.
module address_pairing_change_detector #(
    parameter int unsigned TABLE_ENTRIES = apcd_pkg::TableEntriesDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // interface_id, hw_address, ip_upper, ip_lower, seen_time, now_time
    input  logic [247:0] s_tdata,
    // protected_conflict, is_ipv6
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // interface_changed, after_lease, old_interface, old_hw_address,
    // old_ip_upper, old_ip_lower, age_seconds, pad
    output logic [223:0] m_tdata,
    // event_kind
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    import apcd_pkg::*;

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    // Configuration registers
    logic [31:0] lease_reg;
    logic [7:0]  factor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lease_reg  <= LeaseDefault;
            factor_reg <= FactorDefault;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_LEASE:  lease_reg  <= cfg_data;
                REG_FACTOR: factor_reg <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Control and captured item
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, pos_reg;
    logic [1:0]     nev_reg;
    logic [39:0]    keep_reg;
    entry_t         item_reg;
    logic           prot_reg;
    logic [31:0]    now_reg;
    entry_t         tbl_reg [TABLE_ENTRIES];

    // Output register
    logic           m_tvalid_reg;
    logic [223:0]   m_tdata_reg;
    logic [2:0]     m_tuser_reg;
    logic           m_tlast_reg;

    logic           accept;
    logic           out_free;
    entry_t         in_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Normalise IPv4 addresses on capture
    always_comb
    begin
        in_entry.iface = s_tdata[7:0];
        in_entry.hw    = s_tdata[55:8];
        in_entry.v6    = s_tuser[1];
        in_entry.ip_up = s_tuser[1] ? s_tdata[119:56] : 64'd0;
        in_entry.ip_lo = s_tuser[1] ? s_tdata[183:120] : {32'd0, s_tdata[151:120]};
        in_entry.ts    = s_tdata[215:184];
    end

    // Shared match unit on the entry at the walk position
    entry_t      cur;
    logic        in_range, expired, type_eq, ip_eq, mac_eq, if_eq, ts_le_now, after;
    logic [31:0] age;

    assign in_range  = pos_reg < count_reg;
    assign cur       = tbl_reg[pos_reg[IW-1:0]];
    assign expired   = ({9'd0, cur.ts} + {1'b0, keep_reg}) <= {9'd0, now_reg};
    assign type_eq   = cur.v6 == item_reg.v6;
    assign ip_eq     = type_eq && cur.ip_up == item_reg.ip_up && cur.ip_lo == item_reg.ip_lo;
    assign mac_eq    = cur.hw == item_reg.hw;
    assign if_eq     = cur.iface == item_reg.iface;
    assign ts_le_now = now_reg >= cur.ts;
    assign age       = ts_le_now ? now_reg - cur.ts : 32'd0;
    assign after     = ts_le_now && age >= lease_reg;

    logic walk_refresh, walk_conflict;
    assign walk_refresh  = in_range && !expired && ip_eq && mac_eq;
    assign walk_conflict = in_range && !expired && !walk_refresh && (ip_eq || (mac_eq && type_eq));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = s_tuser[0] ? ST_PROT : ST_WALK;
            end
            ST_PROT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (!in_range)
                    state_next = ST_INSERT;
                else if (walk_refresh && out_free)
                    state_next = ST_IDLE;
            end
            ST_INSERT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Actions: table update, walk position and result load
    table_op_t      op;
    logic           out_load;
    logic [223:0]   out_data;
    logic [2:0]     out_kind;
    logic           out_last;
    logic [CW-1:0]  pos_next;
    logic [1:0]     nev_next;

    always_comb
    begin
        op       = OP_NONE;
        out_load = 1'b0;
        out_data = '0;
        out_kind = EV_NEW;
        out_last = 1'b0;
        pos_next = pos_reg;
        nev_next = nev_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pos_next = '0;
                nev_next = '0;
            end
            ST_PROT:
            begin
                out_load = out_free;
                out_kind = EV_PROTECTED;
                out_last = 1'b1;
            end
            ST_WALK:
            begin
                out_data = {6'd0, age, cur.ip_lo, cur.ip_up, cur.hw, cur.iface,
                            1'b0, !if_eq};
                if (in_range && expired)
                    op = OP_DELETE;
                else if (walk_refresh)
                begin
                    out_kind = EV_REFRESH;
                    out_last = 1'b1;
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        op       = OP_REFRESH;
                    end
                end
                else if (walk_conflict)
                begin
                    out_kind    = ip_eq ? EV_MAC_CHANGED : EV_IP_CHANGED;
                    out_data[1] = after;
                    if (nev_reg >= 2'(MaxChangeEvents))
                        op = OP_DELETE;
                    else if (out_free)
                    begin
                        out_load = 1'b1;
                        op       = OP_DELETE;
                        nev_next = nev_reg + 2'd1;
                    end
                end
                else if (in_range)
                    pos_next = pos_reg + CW'(1);
            end
            ST_INSERT:
            begin
                out_kind = (nev_reg != 2'd0) ? EV_ADDED : EV_NEW;
                out_last = 1'b1;
                if (out_free)
                begin
                    out_load = 1'b1;
                    op       = OP_INSERT;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            nev_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            nev_reg   <= nev_next;
            case (op)
                OP_DELETE: count_reg <= count_reg - CW'(1);
                OP_INSERT:
                begin
                    if (count_reg != CW'(TABLE_ENTRIES))
                        count_reg <= count_reg + CW'(1);
                end
                default: ;
            endcase
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Capture the item and the expiry span
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_entry;
            prot_reg <= s_tuser[0];
            now_reg  <= s_tdata[247:216];
            keep_reg <= {32'd0, factor_reg} * {8'd0, lease_reg};
        end
        if (out_load)
        begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= out_kind;
            m_tlast_reg <= out_last;
        end
    end

    // Table kept in recency order: shift to delete, move to front or insert
    entry_t refreshed;
    always_comb
    begin
        refreshed       = cur;
        refreshed.iface = item_reg.iface;
        refreshed.ts    = item_reg.ts;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            case (op)
                OP_DELETE:
                begin
                    if (i < TABLE_ENTRIES - 1 && IW'(i) >= pos_reg[IW-1:0])
                        tbl_reg[i] <= tbl_reg[(i < TABLE_ENTRIES - 1) ? i + 1 : i];
                end
                OP_REFRESH:
                begin
                    if (i == 0)
                        tbl_reg[i] <= refreshed;
                    else if (IW'(i) <= pos_reg[IW-1:0])
                        tbl_reg[i] <= tbl_reg[(i > 0) ? i - 1 : 0];
                end
                OP_INSERT:
                begin
                    if (i == 0)
                        tbl_reg[i] <= item_reg;
                    else
                        tbl_reg[i] <= tbl_reg[(i > 0) ? i - 1 : 0];
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= count_reg)
        else $error("walk position beyond fill count");

    a_events_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nev_reg <= 2'(MaxChangeEvents))
        else $error("too many change events");

    a_change_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_MAC_CHANGED || m_tuser == EV_IP_CHANGED)) |-> !m_tlast)
        else $error("change event closed the run");

    a_prot_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROT) |-> prot_reg)
        else $error("protected path taken for unprotected item");

endmodule
